FILE: rtl/gic_pkg.sv
`default_nettype none
package gic_pkg;

  localparam int unsigned POS_BITS = 24;
  localparam logic [POS_BITS-1:0] POS_FULL = {POS_BITS{1'b1}};
  localparam logic [POS_BITS-1:0] POS_HALF = {1'b1, {(POS_BITS-1){1'b0}}};
  localparam logic [23:0] IDLE_CLEAR_TICKS = 24'd30000;
  localparam logic [23:0] ELAPSED_MAX = 24'hFFFFFF;

  // operation codes
  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_STOP      = 3'd1;
  localparam logic [2:0] OP_TOGGLE    = 3'd2;
  localparam logic [2:0] OP_GOTO      = 3'd3;
  localparam logic [2:0] OP_OPEN_END  = 3'd4;
  localparam logic [2:0] OP_CLOSE_END = 3'd5;
  localparam logic [2:0] OP_NONE      = 3'd6;

  // motion codes
  localparam logic [1:0] MOT_IDLE  = 2'd0;
  localparam logic [1:0] MOT_OPEN  = 2'd1;
  localparam logic [1:0] MOT_CLOSE = 2'd2;

  // pulse kinds
  localparam logic [1:0] PEND_NONE   = 2'd0;
  localparam logic [1:0] PEND_SINGLE = 2'd1;
  localparam logic [1:0] PEND_DOUBLE = 2'd2;

  // pulse sequence phases
  localparam logic [2:0] PH_NONE    = 3'd0;
  localparam logic [2:0] PH_SINGLE  = 3'd1;
  localparam logic [2:0] PH_DBL_ON1 = 3'd2;
  localparam logic [2:0] PH_DBL_GAP = 3'd3;
  localparam logic [2:0] PH_DBL_ON2 = 3'd4;

  // configuration register indexes
  localparam logic [2:0] REG_OPEN_STEP  = 3'd0;
  localparam logic [2:0] REG_CLOSE_STEP = 3'd1;
  localparam logic [2:0] REG_PULSE_MS   = 3'd2;
  localparam logic [2:0] REG_TIMEOUT    = 3'd3;
  localparam logic [2:0] REG_MAX_CYCLES = 3'd4;

  typedef struct packed {
    logic [2:0]          operation;
    logic [POS_BITS-1:0] target;
  } in_word_t;

  typedef struct packed {
    logic                relay;
    logic [POS_BITS-1:0] position;
    logic [1:0]          motion;
    logic                safety_tripped;
    logic [7:0]          cycles_used;
  } out_word_t;

  // classified command as it travels through the queue
  typedef struct packed {
    logic [2:0]          op;
    logic [POS_BITS-1:0] target;
  } cmd_word_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [15:0] timer;
    logic [15:0] since;
    logic [1:0]  pend;
  } pulse_t;

  typedef struct packed {
    logic push;
  } q_wr_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/impulse_gate_controller.sv
// A word accepted by the front end is written into the command queue; the back end pops it
// and registers its result. Throughput: one word per cycle while the queue is not full and
// the output does not stall; a small command queue decouples intake from output stalls.
// Reset (rst_n low, synchronous): state returns to half open, idle, no pulse, cycle
// count and safety latch clear; configuration registers take their default values.
`default_nettype none
module impulse_gate_controller
  import gic_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [23:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_word_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_word_t        out_data
);

  q_wr_ctl_t wr_ctl;
  cmd_word_t front_cmd;
  cmd_word_t q_data;
  logic      q_full;
  logic      q_valid;
  logic      q_pop;

  gic_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .wr_ctl_o (wr_ctl),
    .q_full   (q_full),
    .cmd_o    (front_cmd)
  );

  gic_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (wr_ctl.push),
    .wr_data  (front_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_data)
  );

  gic_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

FILE: rtl/gic_front.sv
`default_nettype none
module gic_front
  import gic_pkg::*;
(
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_data,
  output q_wr_ctl_t      wr_ctl_o,
  input  wire logic      q_full,
  output cmd_word_t      cmd_o
);

  always_comb begin
    cmd_o.target = in_data.target;
    case (in_data.operation)
      OP_TICK, OP_STOP, OP_TOGGLE, OP_GOTO, OP_OPEN_END, OP_CLOSE_END: begin
        cmd_o.op = in_data.operation;
      end
      // unused codes still produce a result but change nothing
      default: begin
        cmd_o.op = OP_NONE;
      end
    endcase
  end

  assign in_stall      = q_full;
  assign wr_ctl_o.push = in_valid && !q_full;

endmodule
`default_nettype wire

FILE: rtl/gic_queue.sv
`default_nettype none
module gic_queue
  import gic_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire cmd_word_t  wr_data,
  output logic            full,
  input  wire logic       pop,
  output logic            rd_valid,
  output cmd_word_t       rd_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cmd_word_t        slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == CNT_FULL);
  assign rd_valid = (count_r != '0);
  assign rd_data  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/gic_back.sv
`default_nettype none
module gic_back
  import gic_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_addr,
  input  wire logic [23:0] cfg_data,
  input  wire logic       q_valid,
  input  wire cmd_word_t  q_data,
  output logic            q_pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_word_t       out_data
);

  logic [23:0] open_step_r, close_step_r, timeout_r;
  logic [15:0] pulse_ms_r;
  logic [7:0]  max_cycles_r;

  logic [POS_BITS-1:0] pos_r, pos_nxt;
  logic [POS_BITS-1:0] tgt_r, tgt_nxt;
  logic [1:0]  cur_r, cur_nxt;
  logic [1:0]  cmd_r, cmd_nxt;
  logic [1:0]  prev_r, prev_nxt;
  logic [23:0] elapsed_r, elapsed_nxt;
  pulse_t      pulse_r, pulse_nxt;
  logic [7:0]  cyc_r, cyc_nxt;
  logic        latch_r, latch_nxt;

  logic        out_valid_r, out_valid_nxt;
  out_word_t   out_data_r, out_data_nxt;

  function automatic pulse_t launch(pulse_t p, logic [1:0] kind);
    pulse_t q;
    q       = p;
    q.phase = (kind == PEND_DOUBLE) ? PH_DBL_ON1 : PH_SINGLE;
    q.timer = '0;
    q.pend  = PEND_NONE;
    return q;
  endfunction

  function automatic pulse_t request(pulse_t p, logic [1:0] kind, logic [15:0] pw);
    pulse_t q;
    q = p;
    if (p.phase == PH_NONE && p.since >= pw) begin
      q = launch(p, kind);
    end else begin
      q.pend = kind;
    end
    return q;
  endfunction

  function automatic logic [7:0] add_cycles(logic [7:0] c, logic [1:0] n);
    logic [8:0] s;
    s = {1'b0, c} + 9'(n);
    return s[8] ? 8'hFF : s[7:0];
  endfunction

  assign q_pop = q_valid && (!out_valid_r || !out_stall);

  always_comb begin
    logic [15:0]         pw;
    logic [POS_BITS-1:0] room;
    logic                do_start;
    logic [1:0]          start_dir;
    logic [1:0]          kind;
    logic                at_target;

    pw        = (pulse_ms_r == '0) ? 16'd1 : pulse_ms_r;
    room      = POS_FULL - pos_r;
    do_start  = 1'b0;
    start_dir = MOT_IDLE;
    kind      = PEND_NONE;
    at_target = 1'b0;

    pos_nxt     = pos_r;
    tgt_nxt     = tgt_r;
    cur_nxt     = cur_r;
    cmd_nxt     = cmd_r;
    prev_nxt    = prev_r;
    elapsed_nxt = elapsed_r;
    pulse_nxt   = pulse_r;
    cyc_nxt     = cyc_r;
    latch_nxt   = latch_r;

    case (q_data.op)
      OP_TICK: begin
        // advance the pulse sequencer
        if (pulse_nxt.since != 16'hFFFF) begin
          pulse_nxt.since = pulse_nxt.since + 1'b1;
        end
        if (pulse_nxt.phase > PH_DBL_ON2) begin
          pulse_nxt.phase = PH_NONE;
        end
        if (pulse_nxt.phase != PH_NONE) begin
          pulse_nxt.timer = pulse_nxt.timer + 1'b1;
          if (pulse_nxt.timer >= pw) begin
            pulse_nxt.timer = '0;
            if (pulse_nxt.phase == PH_DBL_ON1 || pulse_nxt.phase == PH_DBL_GAP) begin
              pulse_nxt.phase = pulse_nxt.phase + 1'b1;
            end else begin
              pulse_nxt.phase = PH_NONE;
              pulse_nxt.since = '0;
            end
          end
        end
        if (pulse_nxt.phase == PH_NONE && pulse_nxt.pend != PEND_NONE &&
            pulse_nxt.since >= pw) begin
          pulse_nxt = launch(pulse_nxt, pulse_nxt.pend);
        end

        if (elapsed_r != ELAPSED_MAX) begin
          elapsed_nxt = elapsed_r + 1'b1;
        end

        if (cur_r == MOT_IDLE) begin
          if (cyc_r != '0 && elapsed_nxt > IDLE_CLEAR_TICKS) begin
            cyc_nxt = '0;
          end
        end else begin
          if (cur_r == MOT_OPEN) begin
            pos_nxt = (open_step_r >= room) ? POS_FULL : pos_r + open_step_r;
          end else begin
            pos_nxt = (close_step_r >= pos_r) ? '0 : pos_r - close_step_r;
          end

          if (cyc_r >= max_cycles_r) begin
            // trip: stop the gate with one pulse and hold off commands
            latch_nxt   = 1'b1;
            pulse_nxt   = request(pulse_nxt, PEND_SINGLE, pw);
            cyc_nxt     = add_cycles(cyc_r, PEND_SINGLE);
            cmd_nxt     = MOT_IDLE;
            cur_nxt     = MOT_IDLE;
            elapsed_nxt = '0;
          end else if (cmd_r != MOT_IDLE) begin
            at_target = (cmd_r == MOT_OPEN) ? (pos_nxt >= tgt_r) : (pos_nxt <= tgt_r);
            if (at_target) begin
              if (tgt_r != '0 && tgt_r != POS_FULL) begin
                do_start  = 1'b1;
                start_dir = MOT_IDLE;
              end else begin
                cur_nxt     = MOT_IDLE;
                elapsed_nxt = '0;
              end
            end else if (elapsed_nxt > timeout_r) begin
              cur_nxt     = MOT_IDLE;
              elapsed_nxt = '0;
            end
          end
        end
      end
      OP_STOP: begin
        do_start  = 1'b1;
        start_dir = MOT_IDLE;
      end
      OP_TOGGLE: begin
        if (!latch_r) begin
          do_start = 1'b1;
          if (cmd_r != MOT_IDLE) begin
            start_dir = MOT_IDLE;
          end else if (pos_r == '0 || prev_r == MOT_CLOSE) begin
            tgt_nxt   = POS_FULL;
            start_dir = MOT_OPEN;
          end else begin
            tgt_nxt   = '0;
            start_dir = MOT_CLOSE;
          end
        end
      end
      OP_GOTO: begin
        if (!latch_r) begin
          if (q_data.target == pos_r) begin
            if (cur_r != MOT_IDLE || cmd_r != MOT_IDLE) begin
              do_start  = 1'b1;
              start_dir = MOT_IDLE;
            end
          end else begin
            tgt_nxt   = q_data.target;
            do_start  = 1'b1;
            start_dir = (q_data.target < pos_r) ? MOT_CLOSE : MOT_OPEN;
          end
        end
      end
      OP_OPEN_END: begin
        pos_nxt     = POS_FULL;
        cur_nxt     = MOT_IDLE;
        elapsed_nxt = '0;
      end
      OP_CLOSE_END: begin
        pos_nxt     = '0;
        cur_nxt     = MOT_IDLE;
        elapsed_nxt = '0;
      end
      default: begin
      end
    endcase

    // start or stop a commanded motion; always the last action of an item
    if (do_start && !latch_nxt) begin
      case (start_dir)
        MOT_OPEN: begin
          if (pos_nxt == POS_FULL) begin
            kind = PEND_NONE;
          end else if (pos_nxt == '0) begin
            kind = PEND_SINGLE;
          end else begin
            kind = (prev_nxt != MOT_OPEN) ? PEND_SINGLE : PEND_DOUBLE;
          end
        end
        MOT_CLOSE: begin
          if (pos_nxt == '0) begin
            kind = PEND_NONE;
          end else if (pos_nxt == POS_FULL) begin
            kind = PEND_SINGLE;
          end else begin
            kind = (prev_nxt != MOT_CLOSE) ? PEND_SINGLE : PEND_DOUBLE;
          end
        end
        default: begin
          kind = (cur_nxt != MOT_IDLE) ? PEND_SINGLE : PEND_NONE;
        end
      endcase
      if (kind != PEND_NONE) begin
        pulse_nxt = request(pulse_nxt, kind, pw);
        cyc_nxt   = add_cycles(cyc_nxt, kind);
      end
      cmd_nxt     = start_dir;
      cur_nxt     = start_dir;
      elapsed_nxt = '0;
      if (start_dir != MOT_IDLE) begin
        prev_nxt = start_dir;
      end
    end

    out_data_nxt.relay = (pulse_nxt.phase == PH_SINGLE) ||
                         (pulse_nxt.phase == PH_DBL_ON1) ||
                         (pulse_nxt.phase == PH_DBL_ON2);
    out_data_nxt.position       = pos_nxt;
    out_data_nxt.motion         = cur_nxt;
    out_data_nxt.safety_tripped = latch_nxt;
    out_data_nxt.cycles_used    = cyc_nxt;

    out_valid_nxt = q_pop ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_step_r  <= 24'd1678;
      close_step_r <= 24'd1678;
      pulse_ms_r   <= 16'd500;
      timeout_r    <= 24'd60000;
      max_cycles_r <= 8'd10;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_OPEN_STEP:  open_step_r  <= cfg_data;
        REG_CLOSE_STEP: close_step_r <= cfg_data;
        REG_PULSE_MS:   pulse_ms_r   <= cfg_data[15:0];
        REG_TIMEOUT:    timeout_r    <= cfg_data;
        REG_MAX_CYCLES: max_cycles_r <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_HALF;
      tgt_r       <= '0;
      cur_r       <= MOT_IDLE;
      cmd_r       <= MOT_IDLE;
      prev_r      <= MOT_IDLE;
      elapsed_r   <= '0;
      pulse_r     <= '{phase: PH_NONE, timer: 16'd0, since: 16'd500, pend: PEND_NONE};
      cyc_r       <= '0;
      latch_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        pos_r     <= pos_nxt;
        tgt_r     <= tgt_nxt;
        cur_r     <= cur_nxt;
        cmd_r     <= cmd_nxt;
        prev_r    <= prev_nxt;
        elapsed_r <= elapsed_nxt;
        pulse_r   <= pulse_nxt;
        cyc_r     <= cyc_nxt;
        latch_r   <= latch_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire
